// ===== src/handle_slot_table_defines.svh =====
// Assertion helpers for the handle slot table
`ifndef HANDLE_SLOT_TABLE_DEFINES_SVH
`define HANDLE_SLOT_TABLE_DEFINES_SVH

// same-cycle implication
`define HST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hst_pkg.sv =====
package hst_pkg;

    localparam int unsigned ADDR_W = 8;
    localparam int unsigned DEPTH  = 1 << ADDR_W;

    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_port_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] handle_out;
        logic [ADDR_W-1:0] slot_index;
        logic              moved;
        logic [ADDR_W-1:0] moved_from;
    } result_t;

endpackage

// ===== src/handle_slot_table.sv =====
// An accepted beat is registered. In ST_EXEC, once the output register is free,
// the result enters it and raises m_tvalid. Requests are taken one at a time; a
// remove that moves the last slot adds ST_FIX for a second slot-of-handle write.
// A finished result waits in the output register while the next beat is taken.
// Reset clears the free-list head and the handle map valid bits and sets the live
// count to 1; the block takes requests at once after reset, with no clearing pass.
module handle_slot_table
    import hst_pkg::*;
#(
    parameter int unsigned CAPACITY = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] handle_in
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] handle_out, [15:8] slot_index, [16] moved,
                                   // [24:17] moved_from, [31:25] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    mem_port_t         sot_port, hos_port, fn_port;
    logic [ADDR_W-1:0] sot_rdata, hos_rdata, fn_rdata;
    result_t           result;

    hst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req_type  (s_tuser),
        .handle_in (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result),
        .sot_port  (sot_port),
        .sot_rdata (sot_rdata),
        .hos_port  (hos_port),
        .hos_rdata (hos_rdata),
        .fn_port   (fn_port),
        .fn_rdata  (fn_rdata)
    );

    hst_vram u_slot_of_handle (
        .clk   (clk),
        .rst_n (rst_n),
        .port  (sot_port),
        .rdata (sot_rdata)
    );

    hst_ram u_handle_of_slot (
        .clk   (clk),
        .port  (hos_port),
        .rdata (hos_rdata)
    );

    hst_ram u_free_next (
        .clk   (clk),
        .port  (fn_port),
        .rdata (fn_rdata)
    );

    assign m_tdata = {7'd0, result.moved_from, result.moved, result.slot_index,
                      result.handle_out};
    assign m_tuser = result.status;

endmodule

// ===== src/hst_ram.sv =====
module hst_ram
    import hst_pkg::*;
(
    input  logic              clk,
    input  mem_port_t         port,
    output logic [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.waddr] <= port.wdata;
        end
        if (port.re)
        begin
            rdata_reg <= mem[port.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hst_vram.sv =====
module hst_vram
    import hst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_port_t         port,
    output logic [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] data_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.waddr] <= port.wdata;
        end
        if (port.re)
        begin
            data_reg <= mem[port.raddr];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (port.we)
            begin
                valid_reg[port.waddr] <= 1'b1;
            end
            if (port.re)
            begin
                rd_valid_reg <= valid_reg[port.raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? data_reg : '0;

endmodule

// ===== src/hst_ctrl.sv =====
module hst_ctrl
    import hst_pkg::*;
#(
    parameter int unsigned CAPACITY = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        req_type,
    input  logic [ADDR_W-1:0] handle_in,
    output logic              m_tvalid,
    input  logic              m_tready,
    output result_t           result,
    output mem_port_t         sot_port,
    input  logic [ADDR_W-1:0] sot_rdata,
    output mem_port_t         hos_port,
    input  logic [ADDR_W-1:0] hos_rdata,
    output mem_port_t         fn_port,
    input  logic [ADDR_W-1:0] fn_rdata
);

    localparam int unsigned LIMIT     = (CAPACITY < DEPTH) ? CAPACITY : DEPTH;
    localparam logic [ADDR_W:0] LIMIT_C = (ADDR_W + 1)'(LIMIT);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_FIX  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        req_reg, req_next;
    logic [ADDR_W-1:0] h_reg, h_next;
    logic [ADDR_W-1:0] free_head_reg, free_head_next;
    logic [ADDR_W:0]   live_reg, live_next;
    logic [ADDR_W-1:0] lh_reg, lh_next;
    logic [ADDR_W-1:0] fix_slot_reg, fix_slot_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic              out_free;
    logic [ADDR_W:0]   last;
    logic [ADDR_W-1:0] new_slot;
    logic [ADDR_W-1:0] new_handle;
    logic              live_hit;
    logic              do_move;
    result_t           res;

    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign last     = live_reg - (ADDR_W + 1)'(1);
    assign new_slot = live_reg[ADDR_W-1:0];
    assign new_handle = (free_head_reg != '0) ? free_head_reg : new_slot;
    assign live_hit = (h_reg != '0) && (sot_rdata != '0);
    assign do_move  = ({1'b0, sot_rdata} < last);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        h_next         = h_reg;
        free_head_next = free_head_reg;
        live_next      = live_reg;
        lh_next        = lh_reg;
        fix_slot_next  = fix_slot_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;

        sot_port       = '0;
        hos_port       = '0;
        fn_port        = '0;
        sot_port.re    = accept;
        sot_port.raddr = handle_in;
        fn_port.re     = accept;
        fn_port.raddr  = free_head_reg;
        hos_port.re    = accept;
        hos_port.raddr = last[ADDR_W-1:0];

        res            = '0;
        res.status     = STATUS_INVALID;
        res.handle_out = h_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req_type;
                    h_next     = handle_in;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    case (req_reg)
                        REQ_CREATE:
                        begin
                            res.handle_out = '0;
                            if (live_reg >= LIMIT_C)
                            begin
                                res.status = STATUS_FULL;
                            end
                            else
                            begin
                                res.status     = STATUS_OK;
                                res.handle_out = new_handle;
                                res.slot_index = new_slot;
                                if (free_head_reg != '0)
                                begin
                                    free_head_next = fn_rdata;
                                end
                                sot_port.we    = 1'b1;
                                sot_port.waddr = new_handle;
                                sot_port.wdata = new_slot;
                                hos_port.we    = 1'b1;
                                hos_port.waddr = new_slot;
                                hos_port.wdata = new_handle;
                                live_next      = live_reg + (ADDR_W + 1)'(1);
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (live_hit)
                            begin
                                res.status     = STATUS_OK;
                                res.slot_index = sot_rdata;
                                fn_port.we     = 1'b1;
                                fn_port.waddr  = h_reg;
                                fn_port.wdata  = free_head_reg;
                                free_head_next = h_reg;
                                sot_port.we    = 1'b1;
                                sot_port.waddr = h_reg;
                                sot_port.wdata = '0;
                                live_next      = last;
                                if (do_move)
                                begin
                                    res.moved      = 1'b1;
                                    res.moved_from = last[ADDR_W-1:0];
                                    hos_port.we    = 1'b1;
                                    hos_port.waddr = sot_rdata;
                                    hos_port.wdata = hos_rdata;
                                    lh_next        = hos_rdata;
                                    fix_slot_next  = sot_rdata;
                                    state_next     = ST_FIX;
                                end
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            if (live_hit)
                            begin
                                res.status     = STATUS_OK;
                                res.slot_index = sot_rdata;
                            end
                        end
                        default:
                        begin
                            res.status = STATUS_INVALID;
                        end
                    endcase
                    out_next       = res;
                    out_valid_next = 1'b1;
                end
            end
            ST_FIX:
            begin
                // rebind the moved handle to its new slot
                sot_port.we    = 1'b1;
                sot_port.waddr = lh_reg;
                sot_port.wdata = fix_slot_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            live_reg      <= (ADDR_W + 1)'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        h_reg        <= h_next;
        lh_reg       <= lh_next;
        fix_slot_reg <= fix_slot_next;
        out_reg      <= out_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

endmodule

// ===== src/hst_checker.sv =====
`include "handle_slot_table_defines.svh"

module hst_checker
    import hst_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `HST_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    `HST_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready,
        !s_tready, "request taken while previous one is in flight")

    `HST_ASSERT_NOW(a_move_from_tail, clk, rst_n, m_tvalid && m_tdata[16],
        (m_tuser == STATUS_OK) && (m_tdata[24:17] > m_tdata[15:8]),
        "move reported from a slot not above the freed one")

    `HST_ASSERT_NOW(a_full_clean, clk, rst_n, m_tvalid && (m_tuser == STATUS_FULL),
        m_tdata == 32'd0, "full result carries nonzero fields")

    `HST_ASSERT_NOW(a_ok_slot, clk, rst_n, m_tvalid && (m_tuser == STATUS_OK),
        m_tdata[15:8] != 8'd0, "successful result names reserved slot")

endmodule

bind handle_slot_table hst_checker u_hst_checker (.*);

// ===== sim/tb_handle_slot_table.sv =====
module tb_handle_slot_table
    import hst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int unsigned ENTRY_LIMIT = DEPTH;
    localparam int unsigned ITEM_TARGET = 1750;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum int unsigned
    {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } traffic_mix_e;

    class handle_table_tracker;
        logic [7:0]  free_head;
        int unsigned live_count;
        logic [7:0]  free_next [DEPTH];
        logic [7:0]  slot_of_handle [DEPTH];
        logic [7:0]  handle_of_slot [DEPTH];
        result_t     pending_replies [$];
        int unsigned mismatches;
        int unsigned n_created;
        int unsigned n_full;
        int unsigned n_removed;
        int unsigned n_moved;
        int unsigned n_found;
        int unsigned n_invalid;
        int unsigned peak_live;

        function new();
            free_head = '0;
            live_count = 1;
            foreach (slot_of_handle[i])
            begin
                slot_of_handle[i] = '0;
                free_next[i] = '0;
                handle_of_slot[i] = '0;
            end
            mismatches = 0;
            n_created = 0;
            n_full = 0;
            n_removed = 0;
            n_moved = 0;
            n_found = 0;
            n_invalid = 0;
            peak_live = 0;
        endfunction

        function int unsigned pending();
            return pending_replies.size();
        endfunction

        function logic [7:0] pick_live_handle();
            if (live_count <= 1)
                return 8'($urandom_range(0, 255));
            return handle_of_slot[$urandom_range(1, live_count - 1)];
        endfunction

        // advance the table by one accepted request and queue its reply
        function void apply_request(logic [1:0] req, logic [7:0] h);
            result_t     r;
            logic [7:0]  s;
            logic [7:0]  nh;
            logic [7:0]  ns;
            logic [7:0]  lh;
            int unsigned last;
            r = '0;
            r.status = STATUS_INVALID;
            r.handle_out = h;
            if (req == REQ_CREATE)
            begin
                r.handle_out = '0;
                if (live_count >= ENTRY_LIMIT)
                begin
                    r.status = STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    ns = 8'(live_count);
                    if (free_head != 0)
                    begin
                        nh = free_head;
                        free_head = free_next[nh];
                    end
                    else
                        nh = ns;
                    slot_of_handle[nh] = ns;
                    handle_of_slot[ns] = nh;
                    live_count++;
                    if (live_count - 1 > peak_live)
                        peak_live = live_count - 1;
                    r.status = STATUS_OK;
                    r.handle_out = nh;
                    r.slot_index = ns;
                    n_created++;
                end
            end
            else if (req == REQ_REMOVE || req == REQ_LOOKUP)
            begin
                s = slot_of_handle[h];
                if (h != 0 && s != 0)
                begin
                    r.status = STATUS_OK;
                    r.slot_index = s;
                    if (req == REQ_REMOVE)
                    begin
                        last = live_count - 1;
                        free_next[h] = free_head;
                        free_head = h;
                        slot_of_handle[h] = '0;
                        if (s < last)
                        begin
                            lh = handle_of_slot[8'(last)];
                            handle_of_slot[s] = lh;
                            slot_of_handle[lh] = s;
                            r.moved = 1'b1;
                            r.moved_from = 8'(last);
                            n_moved++;
                        end
                        live_count--;
                        n_removed++;
                    end
                    else
                        n_found++;
                end
                else
                    n_invalid++;
            end
            else
                n_invalid++;
            pending_replies.push_back(r);
        endfunction

        function void report_field(string name, int unsigned want, int unsigned got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        endfunction

        function void compare_reply(logic [1:0] status, logic [31:0] data);
            result_t want;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected reply, expected none actual status %0d data %h",
                         $time, status, data);
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status)
                report_field("status", want.status, status);
            if (data[7:0] !== want.handle_out)
                report_field("handle_out", want.handle_out, data[7:0]);
            if (data[15:8] !== want.slot_index)
                report_field("slot_index", want.slot_index, data[15:8]);
            if (data[16] !== want.moved)
                report_field("moved", want.moved, data[16]);
            if (data[24:17] !== want.moved_from)
                report_field("moved_from", want.moved_from, data[24:17]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    handle_table_tracker tracker = new();
    bit          tx_burst;
    bit          rx_burst;
    int unsigned cycle_count;
    int unsigned sent_count;

    handle_slot_table dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, tracker.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            tracker.compare_reply(m_tuser, m_tdata);

    initial
    begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if ($urandom_range(0, 49) == 0)
                rx_burst = !rx_burst;
        end
    end

    task automatic send_beat(input logic [1:0] req, input logic [7:0] h);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= h;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.apply_request(req, h);
        sent_count++;
        if ($urandom_range(0, 49) == 0)
            tx_burst = !tx_burst;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_mix(input traffic_mix_e mix, input int unsigned count);
        int unsigned create_pct;
        int unsigned remove_pct;
        int unsigned lookup_pct;
        int unsigned roll;
        logic [1:0]  req;
        logic [7:0]  h;
        case (mix)
            MIX_FILL:
            begin
                create_pct = 80;
                remove_pct = 8;
                lookup_pct = 9;
            end
            MIX_DRAIN:
            begin
                create_pct = 12;
                remove_pct = 70;
                lookup_pct = 15;
            end
            default:
            begin
                create_pct = 40;
                remove_pct = 35;
                lookup_pct = 20;
            end
        endcase
        for (int unsigned i = 0; i < count && sent_count < ITEM_TARGET + 25; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < create_pct)
                req = REQ_CREATE;
            else if (roll < create_pct + remove_pct)
                req = REQ_REMOVE;
            else if (roll < create_pct + remove_pct + lookup_pct)
                req = REQ_LOOKUP;
            else
                req = REQ_UNKNOWN;
            if ((req == REQ_REMOVE || req == REQ_LOOKUP) && $urandom_range(0, 99) < 85)
                h = tracker.pick_live_handle();
            else
                h = 8'($urandom_range(0, 255));
            send_beat(req, h);
        end
    endtask

    initial
    begin : stimulus
        traffic_mix_e mix;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        cycle_count = 0;
        sent_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_beat(REQ_LOOKUP, 8'h00);
        send_beat(REQ_REMOVE, 8'hFF);
        send_beat(REQ_CREATE, 8'h00);
        send_beat(REQ_LOOKUP, 8'h01);
        send_beat(REQ_REMOVE, 8'h01);
        send_beat(REQ_LOOKUP, 8'h01);
        send_beat(REQ_REMOVE, 8'h01);
        send_beat(REQ_CREATE, 8'hFF);
        send_beat(REQ_CREATE, 8'h00);
        send_beat(REQ_CREATE, 8'h00);
        send_beat(REQ_UNKNOWN, 8'hAA);
        send_beat(REQ_UNKNOWN, 8'h55);
        send_beat(REQ_REMOVE, 8'h01);
        send_beat(REQ_LOOKUP, 8'h03);
        send_beat(REQ_REMOVE, 8'h03);
        send_beat(REQ_CREATE, 8'h00);
        send_beat(REQ_CREATE, 8'h00);
        send_beat(REQ_LOOKUP, 8'hFF);
        send_beat(REQ_LOOKUP, 8'h80);
        send_beat(REQ_REMOVE, 8'h00);
        send_beat(REQ_CREATE, 8'h00);
        hold_until_drained();

        mix = MIX_FILL;
        while (sent_count < ITEM_TARGET + 21)
        begin
            case (mix)
                MIX_FILL:
                begin
                    run_mix(MIX_FILL, 400);
                    mix = MIX_DRAIN;
                end
                MIX_DRAIN:
                begin
                    run_mix(MIX_DRAIN, 350);
                    mix = MIX_BALANCED;
                end
                default:
                begin
                    run_mix(MIX_BALANCED, 200);
                    mix = MIX_FILL;
                end
            endcase
            hold_until_drained();
        end

        repeat (10) @(posedge clk);
        $display("sent %0d requests: %0d creates, %0d full, %0d removes (%0d moved), %0d hits",
                 sent_count, tracker.n_created, tracker.n_full, tracker.n_removed,
                 tracker.n_moved, tracker.n_found);
        $display("invalid or unknown requests %0d, peak occupancy %0d of %0d entries",
                 tracker.n_invalid, tracker.peak_live, ENTRY_LIMIT - 1);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            if (tracker.pending() != 0)
                $display("%0t: %0d expected replies never arrived", $time, tracker.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/hst_pkg.sv
src/hst_ram.sv
src/hst_vram.sv
src/hst_ctrl.sv
src/handle_slot_table.sv
src/hst_checker.sv
sim/tb_handle_slot_table.sv
